// ===== rtl/core/rca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and constants for the radius-2 ring cellular automaton.
// ----------------------------------------------------------------------------
package rca_pkg;

    localparam int ROW_W       = 64;
    localparam int WIDTH_W     = 7;
    localparam int RULE_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int REQ_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int NBHD_W      = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_RING_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_WORD  = 2'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADVANCE = 2'd0,
        REQ_SEED    = 2'd1,
        REQ_LOAD    = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run_start;
        logic last_step;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/rca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_ctrl
// Request sequencer: accept a word, iterate generations, hand off the row.
// ----------------------------------------------------------------------------
module rca_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rca_pkg::dp_status_t status,
    output rca_pkg::ctrl_cmd_t  cmd
);

    rca_pkg::state_t state_reg;
    rca_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rca_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            rca_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.run_start ? rca_pkg::ST_STEP : rca_pkg::ST_EMIT;
                end
            end
            rca_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = rca_pkg::ST_EMIT;
                end
            end
            rca_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rca_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_datapath
// Cell ring, configuration registers, generation logic and output register.
// ----------------------------------------------------------------------------
module rca_datapath
#(
    parameter int MAX_CELLS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rca_pkg::ctrl_cmd_t                  cmd,
    output rca_pkg::dp_status_t                 status,
    input  logic                                cfg_write,
    input  logic [rca_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rca_pkg::RULE_W-1:0]          cfg_data,
    input  logic [rca_pkg::REQ_W-1:0]           req_type,
    input  logic [rca_pkg::COUNT_W-1:0]         step_count,
    input  logic [rca_pkg::ROW_W-1:0]           seed_row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rca_pkg::ROW_W-1:0]           row_out
);

    localparam int CW = $clog2(MAX_CELLS);
    localparam logic [rca_pkg::WIDTH_W-1:0] MAX_W = rca_pkg::WIDTH_W'(MAX_CELLS);

    logic [MAX_CELLS-1:0]              ring_reg;
    logic [MAX_CELLS-1:0]              ring_next;
    logic [MAX_CELLS-1:0]              out_row_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [rca_pkg::WIDTH_W-1:0]       width_reg;
    logic [rca_pkg::WIDTH_W-1:0]       width_next;
    logic [rca_pkg::RULE_W-1:0]        rule_reg;
    logic [rca_pkg::COUNT_W-1:0]       count_reg;
    logic [rca_pkg::COUNT_W-1:0]       count_next;

    logic [rca_pkg::WIDTH_W-1:0]       cfg_width;
    logic [MAX_CELLS-1:0]              mask;
    logic [MAX_CELLS-1:0]              cfg_mask;
    logic [MAX_CELLS-1:0]              gen_row;
    logic [MAX_CELLS+1:0]              ring_pad;
    logic [rca_pkg::WIDTH_W-1:0]       wm1;
    logic [rca_pkg::WIDTH_W-1:0]       wm2;
    logic [rca_pkg::WIDTH_W-1:0]       w_half;
    logic [CW-1:0]                     idx_m1;
    logic [CW-1:0]                     idx_m2;
    logic                              width_one;

    // effective width of a pending width write
    always_comb
    begin
        if (cfg_data[rca_pkg::WIDTH_W-1:0] > MAX_W)
        begin
            cfg_width = MAX_W;
        end
        else if (cfg_data[rca_pkg::WIDTH_W-1:0] == '0)
        begin
            cfg_width = rca_pkg::WIDTH_W'(1);
        end
        else
        begin
            cfg_width = cfg_data[rca_pkg::WIDTH_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_CELLS; i++)
        begin
            mask[i]     = rca_pkg::WIDTH_W'(i) < width_reg;
            cfg_mask[i] = rca_pkg::WIDTH_W'(i) < cfg_width;
        end
    end

    assign ring_pad  = {2'b00, ring_reg};
    assign wm1       = width_reg - rca_pkg::WIDTH_W'(1);
    assign wm2       = width_reg - rca_pkg::WIDTH_W'(2);
    assign width_one = width_reg == rca_pkg::WIDTH_W'(1);
    assign idx_m1    = wm1[CW-1:0];
    assign idx_m2    = width_one ? '0 : wm2[CW-1:0];
    assign w_half    = width_reg >> 1;

    // one generation of every cell, neighborhood wrapped at the ring width
    for (genvar i = 0; i < MAX_CELLS; i++)
    begin : g_cell
        logic                       l2;
        logic                       l1;
        logic                       r1;
        logic                       r2;
        logic [rca_pkg::NBHD_W-1:0] nbhd;

        if (i == 0)
        begin : g_edge0
            assign l2 = ring_reg[idx_m2];
            assign l1 = ring_reg[idx_m1];
        end
        else if (i == 1)
        begin : g_edge1
            assign l2 = ring_reg[idx_m1];
            assign l1 = ring_reg[0];
        end
        else
        begin : g_inner
            assign l2 = ring_reg[i-2];
            assign l1 = ring_reg[i-1];
        end

        assign r1 = (rca_pkg::WIDTH_W'(i+1) == width_reg) ? ring_reg[0] : ring_pad[i+1];
        assign r2 = width_one                                ? ring_reg[0] :
                    (rca_pkg::WIDTH_W'(i+2) == width_reg)   ? ring_reg[0] :
                    (rca_pkg::WIDTH_W'(i+1) == width_reg)   ? ring_pad[1] :
                                                              ring_pad[i+2];
        assign nbhd       = {l2, l1, ring_reg[i], r1, r2};
        assign gen_row[i] = rule_reg[nbhd] & mask[i];
    end

    always_comb
    begin
        ring_next  = ring_reg;
        count_next = count_reg;
        width_next = width_reg;
        if (cfg_write && (cfg_index == rca_pkg::CFG_RING_WIDTH))
        begin
            width_next = cfg_width;
            ring_next  = ring_reg & cfg_mask;
        end
        if (cmd.accept)
        begin
            case (req_type)
                rca_pkg::REQ_ADVANCE:
                begin
                    count_next = step_count;
                end
                rca_pkg::REQ_SEED:
                begin
                    ring_next = '0;
                    ring_next[w_half[CW-1:0]] = 1'b1;
                end
                rca_pkg::REQ_LOAD:
                begin
                    ring_next = seed_row[MAX_CELLS-1:0] & mask;
                end
                default:
                begin
                    ring_next = ring_reg;
                end
            endcase
        end
        if (cmd.step)
        begin
            ring_next  = gen_row;
            count_next = count_reg - rca_pkg::COUNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg      <= '0;
            width_reg     <= MAX_W;
            rule_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ring_reg      <= ring_next;
            width_reg     <= width_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == rca_pkg::CFG_RULE_WORD))
            begin
                rule_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg <= ring_reg;
        end
    end

    assign status.run_start = (req_type == rca_pkg::REQ_ADVANCE) && (step_count != '0);
    assign status.last_step = count_reg == rca_pkg::COUNT_W'(1);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign row_out   = rca_pkg::ROW_W'(out_row_reg);

endmodule

// ===== rtl/core/ring_cellular_automaton_radius2.sv =====
`timescale 1ns / 1ps
// Sequence: an advance of n steps is iterated in ST_STEP for n generations, then ST_EMIT
//   registers the row and raises out_valid; other requests and zero-step advances go straight to ST_EMIT.
// Requests: one request is in flight at a time, and an output stall holds it in ST_EMIT;
//   the single generation stage is reused once per step.
// Reset: cells clear, ring width goes to MAX_CELLS, rule word clears.
// ----------------------------------------------------------------------------
// ring_cellular_automaton_radius2
// Ring of binary cells advanced by a radius-2 one-dimensional automaton.
// ----------------------------------------------------------------------------
module ring_cellular_automaton_radius2
#(
    parameter int MAX_CELLS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rca_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rca_pkg::RULE_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rca_pkg::REQ_W-1:0]       req_type,
    input  logic [rca_pkg::COUNT_W-1:0]     step_count,
    input  logic [rca_pkg::ROW_W-1:0]       seed_row,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rca_pkg::ROW_W-1:0]       row_out
);

    rca_pkg::ctrl_cmd_t  cmd;
    rca_pkg::dp_status_t status;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    rca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rca_datapath #(.MAX_CELLS(MAX_CELLS)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .step_count (step_count),
        .seed_row   (seed_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_out    (row_out)
    );

endmodule

// ===== rtl/core/rca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_checker
// Port-level checks on request sequencing and result words.
// ----------------------------------------------------------------------------
module rca_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [rca_pkg::REQ_W-1:0]   req_type,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [rca_pkg::ROW_W-1:0]   row_out
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_out))
        else $error("result word changed while stalled");

    // one request in flight
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("request accepted while another is in flight");

    // seed gives a single live cell through ST_EMIT and the output register when output is free
    a_seed_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (req_type == rca_pkg::REQ_SEED) && (!out_valid || !out_stall)
        |=> ##1 (out_valid && ($countones(row_out) == 1)))
        else $error("seed request did not return a single live cell");

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word valid right after reset");

endmodule

bind ring_cellular_automaton_radius2 rca_checker u_rca_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_out   (row_out)
);

// ===== tb/ring_cellular_automaton_radius2_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_cellular_automaton_radius2_tb
// Self-checking bench for the radius-2 ring automaton. A scoreboard class
// keeps its own copy of the ring, width and rule, predicts the row for every
// accepted request and compares each returned word in order. Directed
// requests cover seeding, loading, zero and long advances, the ignored
// request code and width changes; random phases then sweep widths (including
// out-of-range ones), rules and request mixes under random idle and stall
// bursts, ending with a phase that runs at full rate.
// ----------------------------------------------------------------------------
module ring_cellular_automaton_radius2_tb;

    localparam logic [rca_pkg::REQ_W-1:0]       REQ_NONE    = 2'd3;
    localparam logic [rca_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rca_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int                              SPAN_LIMIT  = 64;

    class ring_row_checker;
        logic [rca_pkg::ROW_W-1:0]   cells;
        logic [rca_pkg::WIDTH_W-1:0] width_reg;
        logic [rca_pkg::RULE_W-1:0]  rule;
        logic [rca_pkg::ROW_W-1:0]   expected_rows[$];
        int                          errors;

        function new();
            cells     = '0;
            width_reg = 7'd64;
            rule      = '0;
            errors    = 0;
        endfunction

        function int unsigned span();
            int unsigned w;
            w = 32'(width_reg);
            if (w > SPAN_LIMIT)
                w = SPAN_LIMIT;
            if (w == 0)
                w = 1;
            return w;
        endfunction

        function logic [rca_pkg::ROW_W-1:0] span_mask(int unsigned w);
            if (w >= rca_pkg::ROW_W)
                return '1;
            return (64'd1 << w) - 64'd1;
        endfunction

        function logic [rca_pkg::ROW_W-1:0] next_generation(logic [rca_pkg::ROW_W-1:0] row,
                                                            int unsigned w);
            logic [rca_pkg::ROW_W-1:0]  nxt;
            logic [rca_pkg::NBHD_W-1:0] pattern;
            nxt = '0;
            for (int unsigned i = 0; i < w; i++)
            begin
                pattern = {row[6'((i + 2 * w - 2) % w)], row[6'((i + w - 1) % w)],
                           row[6'(i)], row[6'((i + 1) % w)], row[6'((i + 2) % w)]};
                nxt[6'(i)] = rule[pattern];
            end
            return nxt;
        endfunction

        function void write_reg(logic [rca_pkg::CFG_INDEX_W-1:0] index,
                                logic [rca_pkg::RULE_W-1:0] data);
            case (index)
                rca_pkg::CFG_RING_WIDTH:
                begin
                    width_reg = data[rca_pkg::WIDTH_W-1:0];
                    cells &= span_mask(span());
                end
                rca_pkg::CFG_RULE_WORD: rule = data;
                default: ;
            endcase
        endfunction

        function void note_request(logic [rca_pkg::REQ_W-1:0] kind,
                                   logic [rca_pkg::COUNT_W-1:0] steps,
                                   logic [rca_pkg::ROW_W-1:0] seed);
            int unsigned               w;
            logic [rca_pkg::ROW_W-1:0] mask;
            w = span();
            mask = span_mask(w);
            case (kind)
                rca_pkg::REQ_ADVANCE:
                    for (int s = 0; s < int'(steps); s++)
                        cells = next_generation(cells & mask, w);
                rca_pkg::REQ_SEED: cells = 64'd1 << (w / 2);
                rca_pkg::REQ_LOAD: cells = seed;
                default: ;
            endcase
            cells &= mask;
            expected_rows.push_back(cells);
        endfunction

        function void check_row(logic [rca_pkg::ROW_W-1:0] actual);
            logic [rca_pkg::ROW_W-1:0] wanted;
            if (expected_rows.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("row_out %h returned with no request outstanding", actual);
                return;
            end
            wanted = expected_rows.pop_front();
            if (actual !== wanted)
            begin
                errors++;
                if (errors <= 10)
                    $display("row_out mismatch: expected %h actual %h", wanted, actual);
            end
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rca_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rca_pkg::RULE_W-1:0]      cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [rca_pkg::REQ_W-1:0]       req_type;
    logic [rca_pkg::COUNT_W-1:0]     step_count;
    logic [rca_pkg::ROW_W-1:0]       seed_row;
    logic                            out_valid;
    logic                            out_stall;
    logic [rca_pkg::ROW_W-1:0]       row_out;

    ring_row_checker rows = new();
    bit              quiet = 1'b0;
    int              stall_left = 0;

    ring_cellular_automaton_radius2 i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .step_count (step_count),
        .seed_row   (seed_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_out    (row_out)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
                rows.check_row(row_out);
            if (in_valid === 1'b1 && in_stall === 1'b0)
                rows.note_request(req_type, step_count, seed_row);
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                rows.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    task automatic send_request(logic [rca_pkg::REQ_W-1:0] kind,
                                logic [rca_pkg::COUNT_W-1:0] steps,
                                logic [rca_pkg::ROW_W-1:0] seed);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type   <= kind;
        step_count <= steps;
        seed_row   <= seed;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [rca_pkg::CFG_INDEX_W-1:0] index,
                             logic [rca_pkg::RULE_W-1:0] data);
        @(posedge clk);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    task automatic randomize_config();
        logic [rca_pkg::RULE_W-1:0] data;
        drain();
        if ($urandom_range(0, 5) != 0)
        begin
            data = $urandom;
            case ($urandom_range(0, 9))
                0: data[rca_pkg::WIDTH_W-1:0] = rca_pkg::WIDTH_W'($urandom_range(0, 1));
                1: data[rca_pkg::WIDTH_W-1:0] = rca_pkg::WIDTH_W'($urandom_range(2, 10));
                2: data[rca_pkg::WIDTH_W-1:0] = rca_pkg::WIDTH_W'($urandom_range(65, 127));
                3: data[rca_pkg::WIDTH_W-1:0] = 7'd11;
                4: data[rca_pkg::WIDTH_W-1:0] = 7'd64;
                default: data[rca_pkg::WIDTH_W-1:0] = rca_pkg::WIDTH_W'($urandom_range(11, 64));
            endcase
            write_cfg(rca_pkg::CFG_RING_WIDTH, data);
        end
        if ($urandom_range(0, 3) == 0)
            write_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        case ($urandom_range(0, 7))
            0: write_cfg(rca_pkg::CFG_RULE_WORD, 32'h0000_0000);
            1: write_cfg(rca_pkg::CFG_RULE_WORD, 32'hFFFF_FFFF);
            default: write_cfg(rca_pkg::CFG_RULE_WORD, $urandom);
        endcase
    endtask

    task automatic run_phase(int count);
        logic [rca_pkg::REQ_W-1:0]   kind;
        logic [rca_pkg::COUNT_W-1:0] steps;
        int                          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                kind = rca_pkg::REQ_ADVANCE;
            else if (pick < 8)
                kind = rca_pkg::REQ_LOAD;
            else if (pick < 9)
                kind = rca_pkg::REQ_SEED;
            else
                kind = REQ_NONE;
            steps = ($urandom_range(0, 6) == 0) ? rca_pkg::COUNT_W'($urandom_range(0, 255)) :
                                                  rca_pkg::COUNT_W'($urandom_range(0, 8));
            send_request(kind, steps, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = '0;
        step_count = '0;
        seed_row   = '0;
        out_stall  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_NONE, 8'd0, '0);
        send_request(rca_pkg::REQ_ADVANCE, 8'd3, '1);
        drain();
        write_cfg(rca_pkg::CFG_RULE_WORD, 32'h5A5A_3C96);
        send_request(rca_pkg::REQ_SEED, 8'd0, '0);
        send_request(rca_pkg::REQ_ADVANCE, 8'd1, '0);
        send_request(rca_pkg::REQ_ADVANCE, 8'd0, '1);
        send_request(rca_pkg::REQ_ADVANCE, 8'd255, '0);
        send_request(rca_pkg::REQ_LOAD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(rca_pkg::REQ_ADVANCE, 8'd1, '0);
        send_request(rca_pkg::REQ_LOAD, 8'd0, 64'h8000_0000_0000_0001);
        send_request(rca_pkg::REQ_ADVANCE, 8'd7, '0);
        send_request(rca_pkg::REQ_LOAD, 8'd0, '0);
        send_request(REQ_NONE, 8'hAA, 64'h5555_5555_5555_5555);
        drain();
        write_cfg(rca_pkg::CFG_RING_WIDTH, 32'd11);
        write_cfg(rca_pkg::CFG_RULE_WORD, 32'hFFFF_FFFF);
        write_cfg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_cfg(CFG_SPARE_B, 32'h1234_5678);
        send_request(rca_pkg::REQ_LOAD, 8'd0, '1);
        send_request(rca_pkg::REQ_SEED, 8'd0, '0);
        send_request(rca_pkg::REQ_ADVANCE, 8'd3, '0);
        drain();
        write_cfg(rca_pkg::CFG_RING_WIDTH, 32'd64);
        write_cfg(rca_pkg::CFG_RULE_WORD, 32'h0000_0000);
        send_request(rca_pkg::REQ_LOAD, 8'd0, 64'hDEAD_BEEF_CAFE_F00D);
        drain();
        write_cfg(rca_pkg::CFG_RING_WIDTH, 32'd20);
        send_request(REQ_NONE, 8'd0, '0);
        drain();
        write_cfg(rca_pkg::CFG_RING_WIDTH, 32'd64);
        send_request(REQ_NONE, 8'd0, '0);
        drain();
        write_cfg(rca_pkg::CFG_RING_WIDTH, 32'hFFFF_FF80);
        send_request(rca_pkg::REQ_SEED, 8'd0, '0);
        drain();
        write_cfg(rca_pkg::CFG_RING_WIDTH, 32'd127);
        write_cfg(rca_pkg::CFG_RULE_WORD, 32'h6996_9669);
        send_request(rca_pkg::REQ_SEED, 8'd0, '0);
        send_request(rca_pkg::REQ_ADVANCE, 8'd5, '0);

        for (int p = 0; p < 7; p++)
        begin
            randomize_config();
            run_phase(115);
        end
        randomize_config();
        quiet = 1'b1;
        run_phase(140);

        drain();
        repeat (8) @(posedge clk);
        if (rows.errors == 0)
            $display("ring_cellular_automaton_radius2: match");
        else
            $display("ring_cellular_automaton_radius2: mismatch");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("ring_cellular_automaton_radius2: mismatch");
        $finish;
    end

endmodule
